[rtl/msc_pkg.sv]
// Shared types and constants of the mode select container.
package msc_pkg;

	localparam int CAPACITY_DEF   = 32;
	localparam int DATA_WIDTH_DEF = 8;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] MODE_FIFO = 2'd0;
	localparam logic [1:0] MODE_LIFO = 2'd1;
	localparam logic [1:0] MODE_SET  = 2'd2;
	localparam logic [1:0] MODE_PQ   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} cmd_t;

	typedef struct packed {
		logic has;
		logic found;
	} scan_flags_t;

endpackage

[rtl/msc_cell.sv]
// One storage cell of the chain: a held value and one stage of the scan wave.
module msc_cell #(
	parameter int DW     = 8,
	parameter int CNT_W  = 6,
	parameter int POS_W  = 5,
	parameter int INDEX  = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msc_pkg::cmd_t        cmd,
	input  logic [POS_W-1:0]     pos,
	input  logic [CNT_W-1:0]     count,
	input  logic [DW-1:0]        key,
	input  logic [DW-1:0]        right_val,
	input  msc_pkg::scan_flags_t flags_in,
	input  logic [DW-1:0]        first_in,
	input  logic [DW-1:0]        last_in,
	input  logic [DW-1:0]        best_in,
	input  logic [POS_W-1:0]     best_pos_in,
	output logic [DW-1:0]        val,
	output msc_pkg::scan_flags_t flags_out,
	output logic [DW-1:0]        first_out,
	output logic [DW-1:0]        last_out,
	output logic [DW-1:0]        best_out,
	output logic [POS_W-1:0]     best_pos_out
);
	import msc_pkg::*;

	localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(INDEX);
	localparam logic [POS_W-1:0] IDX_POS = POS_W'(INDEX);

	logic [DW-1:0]    val_q;
	scan_flags_t      flags_q, flags_d;
	logic [DW-1:0]    first_q, first_d;
	logic [DW-1:0]    last_q, last_d;
	logic [DW-1:0]    best_q, best_d;
	logic [POS_W-1:0] best_pos_q, best_pos_d;
	logic             occ;

	assign occ = IDX_CNT < count;

	always_comb begin
		flags_d    = flags_in;
		first_d    = first_in;
		last_d     = last_in;
		best_d     = best_in;
		best_pos_d = best_pos_in;
		if (occ) begin
			flags_d.has   = 1'b1;
			flags_d.found = flags_in.found | (val_q == key);
			last_d        = val_q;
			if (!flags_in.has) begin
				first_d = val_q;
			end
			if (!flags_in.has || (val_q < best_in)) begin
				best_d     = val_q;
				best_pos_d = IDX_POS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q    <= '0;
			first_q    <= '0;
			last_q     <= '0;
			best_q     <= '0;
			best_pos_q <= '0;
		end else begin
			flags_q    <= flags_d;
			first_q    <= first_d;
			last_q     <= last_d;
			best_q     <= best_d;
			best_pos_q <= best_pos_d;
		end
	end

	// close up behind a removed element, or take a new one at the tail
	always_ff @(posedge clk) begin
		if (cmd.shift && (IDX_POS >= pos)) begin
			val_q <= right_val;
		end else if (cmd.ins && (IDX_CNT == count)) begin
			val_q <= key;
		end
	end

	assign val          = val_q;
	assign flags_out    = flags_q;
	assign first_out    = first_q;
	assign last_out     = last_q;
	assign best_out     = best_q;
	assign best_pos_out = best_pos_q;

endmodule

[rtl/msc_chain.sv]
// Row of storage cells linked neighbour to neighbour.
module msc_chain #(
	parameter int CAPACITY = 32,
	parameter int DW       = 8,
	parameter int CNT_W    = 6,
	parameter int POS_W    = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msc_pkg::cmd_t        cmd,
	input  logic [POS_W-1:0]     pos,
	input  logic [CNT_W-1:0]     count,
	input  logic [DW-1:0]        key,
	output msc_pkg::scan_flags_t flags,
	output logic [DW-1:0]        first_val,
	output logic [DW-1:0]        last_val,
	output logic [DW-1:0]        best_val,
	output logic [POS_W-1:0]     best_pos
);
	import msc_pkg::*;

	logic [DW-1:0]    val_w      [CAPACITY];
	scan_flags_t      flags_w    [CAPACITY+1];
	logic [DW-1:0]    first_w    [CAPACITY+1];
	logic [DW-1:0]    last_w     [CAPACITY+1];
	logic [DW-1:0]    best_w     [CAPACITY+1];
	logic [POS_W-1:0] best_pos_w [CAPACITY+1];

	assign flags_w[0]    = '0;
	assign first_w[0]    = '0;
	assign last_w[0]     = '0;
	assign best_w[0]     = '0;
	assign best_pos_w[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DW-1:0] right_w;
		if (i == CAPACITY - 1) begin : g_end
			assign right_w = val_w[i];
		end else begin : g_mid
			assign right_w = val_w[i+1];
		end
		msc_cell #(
			.DW    (DW),
			.CNT_W (CNT_W),
			.POS_W (POS_W),
			.INDEX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.pos          (pos),
			.count        (count),
			.key          (key),
			.right_val    (right_w),
			.flags_in     (flags_w[i]),
			.first_in     (first_w[i]),
			.last_in      (last_w[i]),
			.best_in      (best_w[i]),
			.best_pos_in  (best_pos_w[i]),
			.val          (val_w[i]),
			.flags_out    (flags_w[i+1]),
			.first_out    (first_w[i+1]),
			.last_out     (last_w[i+1]),
			.best_out     (best_w[i+1]),
			.best_pos_out (best_pos_w[i+1])
		);
	end

	assign flags     = flags_w[CAPACITY];
	assign first_val = first_w[CAPACITY];
	assign last_val  = last_w[CAPACITY];
	assign best_val  = best_w[CAPACITY];
	assign best_pos  = best_pos_w[CAPACITY];

endmodule

[rtl/msc_ctrl.sv]
// Sequencer: takes a word, waits out the scan wave, decides and drives the result register.
module msc_ctrl #(
	parameter int CAPACITY = 32,
	parameter int DW       = 8,
	parameter int CNT_W    = 6,
	parameter int POS_W    = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_op,
	input  logic [DW-1:0]        in_value,
	input  logic [1:0]           discipline,
	input  msc_pkg::scan_flags_t flags,
	input  logic [DW-1:0]        first_val,
	input  logic [DW-1:0]        last_val,
	input  logic [DW-1:0]        best_val,
	input  logic [POS_W-1:0]     best_pos,
	output msc_pkg::cmd_t        cmd,
	output logic [POS_W-1:0]     pos,
	output logic [CNT_W-1:0]     count,
	output logic [DW-1:0]        key,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DW-1:0]        out_removed,
	output logic                 out_empty,
	output logic [1:0]           out_status
);
	import msc_pkg::*;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
	localparam logic [POS_W-1:0] LAST_STEP = POS_W'(CAPACITY - 1);

	state_t           state_q, state_d;
	logic [POS_W-1:0] step_q;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [1:0]       op_q;
	logic [DW-1:0]    key_q;
	logic             out_valid_q;
	logic [DW-1:0]    removed_q;
	logic             empty_q;
	logic [1:0]       status_q;

	logic             out_free;
	logic             load;
	logic             do_ins, do_shift;
	logic [DW-1:0]    res_removed;
	logic [1:0]       res_status;
	logic [POS_W-1:0] rm_pos;
	logic [CNT_W-1:0] last_idx;

	assign out_free = !out_valid_q || out_ready;
	assign last_idx = fill_q - CNT_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (step_q == LAST_STEP) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		load     = (state_q == S_DONE) && out_free;
	end

	always_comb begin
		do_ins      = 1'b0;
		do_shift    = 1'b0;
		res_removed = '0;
		res_status  = ST_OK;
		fill_d      = fill_q;
		case (discipline)
			MODE_FIFO: rm_pos = '0;
			MODE_LIFO: rm_pos = last_idx[POS_W-1:0];
			default:   rm_pos = best_pos;
		endcase
		case (op_q)
			OP_INSERT: begin
				if ((discipline == MODE_SET) && flags.found) begin
					res_status = ST_OK;
				end else if (fill_q == FULL_CNT) begin
					res_status = ST_OVERFLOW;
				end else begin
					do_ins = 1'b1;
					fill_d = fill_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (fill_q == '0) begin
					res_status = ST_UNDERFLOW;
				end else begin
					do_shift = 1'b1;
					fill_d   = last_idx;
					case (discipline)
						MODE_FIFO: res_removed = first_val;
						MODE_LIFO: res_removed = last_val;
						default:   res_removed = best_val;
					endcase
				end
			end
			default: res_status = ST_OK;
		endcase
	end

	assign cmd.ins   = load && do_ins;
	assign cmd.shift = load && do_shift;
	assign pos       = rm_pos;
	assign count     = fill_q;
	assign key       = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_ready && in_valid) begin
				step_q <= '0;
			end else if (state_q == S_SCAN) begin
				step_q <= step_q + POS_W'(1);
			end
			if (load) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_q  <= in_op;
			key_q <= in_value;
		end
		if (load) begin
			removed_q <= res_removed;
			empty_q   <= (fill_d == '0);
			status_q  <= res_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_removed = removed_q;
	assign out_empty   = empty_q;
	assign out_status  = status_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond capacity");

	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(fill_q))
		else $error("fill count moved without a result");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + CNT_W'(1))
			|| (fill_q + CNT_W'(1) == $past(fill_q)))
		else $error("fill count moved by more than one");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_UNDERFLOW) |-> empty_q && (removed_q == '0))
		else $error("underflow result inconsistent");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_OVERFLOW) |-> !empty_q)
		else $error("overflow reported on empty store");
`endif

endmodule

[rtl/mode_select_container.sv]
// Top level of the mode select container: stream ports, mode register, cell row.
//
// Usage:
//   s_* carries one command word: s_tuser is the operation (insert, query,
//   remove), s_tdata the value to insert. m_* returns one result word per
//   command: m_tdata holds the removed value and the empty flag, m_tuser the
//   status (ok, underflow, overflow).
//   cfg_* writes the discipline register (fifo, lifo, set, priority queue);
//   write it only while no command is outstanding. cfg_ready is always high.
//   Commands are handled one at a time. After a word is taken, the scan
//   wave runs down the row of CAPACITY cells, one cell per cycle; the scan
//   result is then registered in the result register, and no new word is
//   taken before the result of the last one has been registered.
//   If m_tready is low the result is held and the finished command waits;
//   the next word is taken as soon as that result has moved on, and its
//   result is held until the register is free.
//   Reset empties the store and selects fifo; cell contents are not cleared.
module mode_select_container #(
	parameter int CAPACITY   = msc_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = msc_pkg::DATA_WIDTH_DEF,
	parameter int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8,
	parameter int OUT_TDATA_W = ((DATA_WIDTH + 1 + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // value
	input  logic [1:0]             s_tuser,  // operation
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // removed_value, is_empty
	output logic [1:0]             m_tuser   // status
);
	import msc_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = $clog2(CAPACITY);

	logic [1:0]            discipline_q;
	cmd_t                  cmd;
	scan_flags_t           flags;
	logic [POS_W-1:0]      pos, best_pos;
	logic [CNT_W-1:0]      count;
	logic [DATA_WIDTH-1:0] key, first_val, last_val, best_val, removed;
	logic                  is_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discipline_q <= MODE_FIFO;
		end else if (cfg_valid && cfg_ready) begin
			discipline_q <= cfg_data;
		end
	end

	msc_chain #(
		.CAPACITY (CAPACITY),
		.DW       (DATA_WIDTH),
		.CNT_W    (CNT_W),
		.POS_W    (POS_W)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pos       (pos),
		.count     (count),
		.key       (key),
		.flags     (flags),
		.first_val (first_val),
		.last_val  (last_val),
		.best_val  (best_val),
		.best_pos  (best_pos)
	);

	msc_ctrl #(
		.CAPACITY (CAPACITY),
		.DW       (DATA_WIDTH),
		.CNT_W    (CNT_W),
		.POS_W    (POS_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (s_tuser),
		.in_value    (s_tdata[DATA_WIDTH-1:0]),
		.discipline  (discipline_q),
		.flags       (flags),
		.first_val   (first_val),
		.last_val    (last_val),
		.best_val    (best_val),
		.best_pos    (best_pos),
		.cmd         (cmd),
		.pos         (pos),
		.count       (count),
		.key         (key),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_removed (removed),
		.out_empty   (is_empty),
		.out_status  (m_tuser)
	);

	assign m_tdata = OUT_TDATA_W'({is_empty, removed});

endmodule

[test/tb_top.sv]
// Testbench of mode_select_container: command streams in all four disciplines, checked per word.
`timescale 1ns / 100ps

module tb_top;
	import msc_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1300;

	typedef struct packed {
		logic [7:0] removed;
		logic       empty;
		logic [1:0] status;
	} result_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data  = MODE_FIFO;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;  // value
	logic [1:0]  s_tuser   = OP_QUERY;  // operation
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;  // removed_value, is_empty
	logic [1:0]  m_tuser;  // status

	logic [7:0] held_values[$];
	logic [1:0] discipline_now = MODE_FIFO;
	result_t    awaited_results[$];

	int fail_count  = 0;
	int ok_seen     = 0;
	int under_seen  = 0;
	int over_seen   = 0;
	int cfg_writes  = 0;
	int random_sent = 0;
	int burst_left  = 0;
	bit steady      = 1'b0;
	int stall_left  = 0;
	int stall_kind  = 0;
	int stall_phase = 0;

	mode_select_container DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic result_t container_predict(logic [1:0] op, logic [7:0] val);
		result_t r;
		bit      dup;
		int      pos;
		r.removed = 8'h00;
		r.status  = ST_OK;
		dup       = 1'b0;
		pos       = 0;
		if (op == OP_INSERT) begin
			foreach (held_values[i])
				if (held_values[i] == val)
					dup = 1'b1;
			if (discipline_now == MODE_SET && dup) begin
				r.status = ST_OK;
			end else if (held_values.size() >= CAPACITY) begin
				r.status = ST_OVERFLOW;
			end else begin
				held_values.insert(held_values.size(), val);
			end
		end else if (op == OP_REMOVE) begin
			if (held_values.size() == 0) begin
				r.status = ST_UNDERFLOW;
			end else if (discipline_now == MODE_FIFO) begin
				r.removed = held_values.pop_front();
			end else if (discipline_now == MODE_LIFO) begin
				r.removed = held_values[held_values.size() - 1];
				held_values.delete(held_values.size() - 1);
			end else begin
				foreach (held_values[i])
					if (held_values[i] < held_values[pos])
						pos = i;
				r.removed = held_values[pos];
				held_values.delete(pos);
			end
		end
		r.empty = (held_values.size() == 0);
		return r;
	endfunction

	function automatic logic [7:0] pick_value(bit narrow);
		if (narrow)
			return 8'($urandom_range(0, 7));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_word(input logic [1:0] op, input logic [7:0] val);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (!steady && $urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		awaited_results.insert(awaited_results.size(), container_predict(op, val));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_discipline(input logic [1:0] mode);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		discipline_now = mode;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: segments of free flow, coin flips, a fixed duty cycle and rarely ready
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_kind = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 300);
		end
		stall_left--;
		stall_phase++;
		case (stall_kind)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ((stall_phase % 9) >= 4);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.removed = m_tdata[7:0];
			got.empty   = m_tdata[8];
			got.status  = m_tuser;
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result word expected none got %h", $time, got);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (got.removed !== want.removed) begin
					$display("%0t: removed_value expected %0h got %0h", $time,
						want.removed, got.removed);
					fail_count++;
				end
				if (got.empty !== want.empty) begin
					$display("%0t: is_empty expected %0b got %0b", $time,
						want.empty, got.empty);
					fail_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, got.status);
					fail_count++;
				end
				case (want.status)
					ST_UNDERFLOW: under_seen++;
					ST_OVERFLOW:  over_seen++;
					default:      ok_seen++;
				endcase
			end
		end
	end

	task automatic test_empty_after_reset();
		send_word(OP_QUERY, 8'hFF);
		send_word(OP_REMOVE, 8'hA5);
		send_word(2'd3, 8'h5A);
	endtask

	task automatic test_fifo_order();
		send_word(OP_INSERT, 8'h00);
		send_word(OP_INSERT, 8'hFF);
		send_word(OP_INSERT, 8'h80);
		send_word(OP_REMOVE, 8'h00);
		send_word(OP_REMOVE, 8'h00);
	endtask

	task automatic test_lifo_order();
		set_discipline(MODE_LIFO);
		send_word(OP_INSERT, 8'h01);
		send_word(OP_INSERT, 8'h7F);
		send_word(OP_REMOVE, 8'h00);
	endtask

	task automatic test_priority_duplicates();
		set_discipline(MODE_PQ);
		send_word(OP_INSERT, 8'h01);
		send_word(OP_INSERT, 8'h00);
		send_word(OP_REMOVE, 8'h00);
	endtask

	// set now holds a duplicate left by the priority queue
	task automatic test_set_duplicates();
		set_discipline(MODE_SET);
		send_word(OP_INSERT, 8'h80);
		send_word(OP_INSERT, 8'h01);
		send_word(OP_INSERT, 8'h55);
		send_word(OP_REMOVE, 8'h00);
		send_word(OP_REMOVE, 8'h00);
		send_word(OP_REMOVE, 8'h00);
		send_word(OP_REMOVE, 8'h00);
		send_word(OP_REMOVE, 8'h00);
	endtask

	task automatic run_fill_drain();
		int n_ins;
		int n_rem;
		logic [7:0] v;
		n_ins = CAPACITY - held_values.size() + $urandom_range(1, 6);
		repeat (n_ins) begin
			if (held_values.size() >= CAPACITY && $urandom_range(0, 1) == 1)
				v = held_values[$urandom_range(0, held_values.size() - 1)];
			else
				v = pick_value(1'b0);
			send_word(OP_INSERT, v);
			if ($urandom_range(0, 9) == 0)
				send_word(OP_QUERY, pick_value(1'b0));
		end
		n_rem = held_values.size() + $urandom_range(1, 4);
		repeat (n_rem) begin
			send_word(OP_REMOVE, pick_value(1'b0));
			if ($urandom_range(0, 9) == 0)
				send_word(OP_QUERY, pick_value(1'b0));
		end
		random_sent += n_ins + n_rem;
	endtask

	task automatic run_mixed();
		int len;
		int w;
		bit narrow;
		len    = $urandom_range(30, 80);
		narrow = $urandom_range(0, 1);
		repeat (len) begin
			w = $urandom_range(0, 99);
			if (w < 45)
				send_word(OP_INSERT, pick_value(narrow));
			else if (w < 85)
				send_word(OP_REMOVE, pick_value(1'b0));
			else
				send_word(OP_QUERY, pick_value(1'b0));
		end
		random_sent += len;
	endtask

	task automatic run_noise();
		int len;
		len = $urandom_range(15, 40);
		repeat (len)
			send_word(2'($urandom_range(0, 3)), pick_value(1'b0));
		random_sent += len;
	endtask

	task automatic test_random_traffic();
		int phase;
		int kind;
		logic [1:0] mode;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (phase < 4)
				mode = 2'(phase);
			else
				mode = 2'($urandom_range(0, 3));
			set_discipline(mode);
			steady = ($urandom_range(0, 4) == 0);
			kind   = $urandom_range(0, 9);
			if (kind < 4)
				run_fill_drain();
			else if (kind < 8)
				run_mixed();
			else
				run_noise();
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_after_reset();
		test_fifo_order();
		test_lifo_order();
		test_priority_duplicates();
		test_set_duplicates();
		test_random_traffic();
		drain_results();
		repeat (4 * CAPACITY) @(posedge clk);
		$display("Summary: %0d result words checked: %0d ok, %0d underflow, %0d overflow",
			ok_seen + under_seen + over_seen, ok_seen, under_seen, over_seen);
		$display("Summary: %0d discipline writes over fifo, lifo, set and priority queue",
			cfg_writes);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
